FILE: src/clas_pkg.sv
// Shared types and constants for the command line argument splitter.
package clas_pkg;

   localparam int MAX_PENDING_BACKSLASHES = 255;
   localparam int BS_CAP_INT = (MAX_PENDING_BACKSLASHES < 255) ? MAX_PENDING_BACKSLASHES : 255;
   localparam logic [7:0] BS_CAP = BS_CAP_INT[7:0];

   localparam logic [15:0] CH_NUL       = 16'h0000;
   localparam logic [15:0] CH_QUOTE     = 16'h0022;
   localparam logic [15:0] CH_BACKSLASH = 16'h005C;
   localparam logic [15:0] CH_TAB       = 16'h0009;
   localparam logic [15:0] CH_SPACE     = 16'h0020;

   localparam int CMD_DEPTH = 4;
   localparam int CMD_PTR_W = $clog2(CMD_DEPTH);
   localparam int CMD_CNT_W = $clog2(CMD_DEPTH + 1);

   typedef enum logic [1:0] {
      KIND_RUN      = 2'd0,
      KIND_ARG_END  = 2'd1,
      KIND_LINE_END = 2'd2
   } kind_type;

   typedef struct packed {
      logic [7:0]  bs_count;
      logic        has_char;
      logic [15:0] ch;
      logic        arg_end;
      logic        line_end;
   } cmd_type;

endpackage

FILE: src/clas_front.sv
// Front end: accepts characters, tracks quote and backslash state, builds commands.
module clas_front (
   input  logic            clock,
   input  logic            reset,
   input  logic            accept,
   input  logic [15:0]     char_code,
   output logic            push,
   output clas_pkg::cmd_type cmd
);
   import clas_pkg::*;

   logic       quoted_ff, quoted_in;
   logic       empty_ff, empty_in;
   logic [7:0] pend_ff, pend_in;

   always_comb begin
      quoted_in = quoted_ff;
      empty_in  = empty_ff;
      pend_in   = 8'd0;
      cmd       = '0;
      if (char_code == CH_BACKSLASH) begin
         pend_in  = (pend_ff < BS_CAP) ? pend_ff + 8'd1 : pend_ff;
         empty_in = 1'b0;
      end else if (char_code == CH_NUL) begin
         cmd.bs_count = pend_ff;
         cmd.arg_end  = ~empty_ff;
         cmd.line_end = 1'b1;
         quoted_in    = 1'b0;
         empty_in     = 1'b1;
      end else if (char_code == CH_QUOTE) begin
         cmd.bs_count = {1'b0, pend_ff[7:1]};
         cmd.has_char = pend_ff[0];
         cmd.ch       = CH_QUOTE;
         quoted_in    = pend_ff[0] ? quoted_ff : ~quoted_ff;
         empty_in     = 1'b0;
      end else if (char_code == CH_SPACE || char_code == CH_TAB) begin
         cmd.bs_count = pend_ff;
         if (quoted_ff) begin
            cmd.has_char = 1'b1;
            cmd.ch       = char_code;
         end else if (!empty_ff) begin
            cmd.arg_end = 1'b1;
            empty_in    = 1'b1;
         end
      end else begin
         cmd.bs_count = pend_ff;
         cmd.has_char = 1'b1;
         cmd.ch       = char_code;
         empty_in     = 1'b0;
      end
   end

   assign push = accept &&
                 (cmd.bs_count != 8'd0 || cmd.has_char || cmd.arg_end || cmd.line_end);

   always_ff @(posedge clock) begin
      if (reset) begin
         quoted_ff <= 1'b0;
         empty_ff  <= 1'b1;
         pend_ff   <= 8'd0;
      end else if (accept) begin
         quoted_ff <= quoted_in;
         empty_ff  <= empty_in;
         pend_ff   <= pend_in;
      end
   end

endmodule

FILE: src/clas_cmd_fifo.sv
// Short command queue between the front end and the result sequencer.
module clas_cmd_fifo (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  clas_pkg::cmd_type push_cmd,
   output logic              full,
   input  logic              pop,
   output logic              head_valid,
   output clas_pkg::cmd_type head_cmd
);
   import clas_pkg::*;

   cmd_type                mem [CMD_DEPTH];
   logic [CMD_PTR_W-1:0]   wr_ptr_ff, rd_ptr_ff;
   logic [CMD_CNT_W-1:0]   count_ff;
   logic                   do_push, do_pop;

   assign full       = (count_ff == CMD_CNT_W'(CMD_DEPTH));
   assign head_valid = (count_ff != '0);
   assign head_cmd   = mem[rd_ptr_ff];
   assign do_push    = push && !full;
   assign do_pop     = pop && head_valid;

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem[wr_ptr_ff] <= push_cmd;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (do_push) begin
            wr_ptr_ff <= wr_ptr_ff + CMD_PTR_W'(1);
         end
         if (do_pop) begin
            rd_ptr_ff <= rd_ptr_ff + CMD_PTR_W'(1);
         end
         unique case ({do_push, do_pop})
            2'b10:   count_ff <= count_ff + CMD_CNT_W'(1);
            2'b01:   count_ff <= count_ff - CMD_CNT_W'(1);
            default: count_ff <= count_ff;
         endcase
      end
   end

endmodule

FILE: src/clas_back.sv
// Back end: expands each queued command into result transfers, one per cycle while rsp_tready is high.
module clas_back (
   input  logic              clock,
   input  logic              reset,
   input  logic              head_valid,
   input  clas_pkg::cmd_type head_cmd,
   output logic              pop,
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   output logic [23:0]       rsp_tdata,
   output logic [1:0]        rsp_tuser,
   output logic              rsp_tlast
);
   import clas_pkg::*;

   logic [3:0]  done_ff, done_in;
   logic [3:0]  parts, remain, sel;
   logic        valid_ff, valid_in;
   logic        load, last;
   kind_type    kind_ff, kind_in;
   logic [15:0] char_ff, char_in;
   logic [7:0]  cnt_ff, cnt_in;
   logic        tlast_ff;

   assign parts  = {head_cmd.line_end, head_cmd.arg_end, head_cmd.has_char,
                    head_cmd.bs_count != 8'd0};
   assign remain = parts & ~done_ff;
   assign last   = ((remain & ~sel) == 4'd0);
   assign load   = head_valid && (!valid_ff || rsp_tready);
   assign pop    = load && last;

   always_comb begin
      sel     = 4'd0;
      kind_in = KIND_RUN;
      char_in = 16'd0;
      cnt_in  = 8'd0;
      priority if (remain[0]) begin
         sel     = 4'b0001;
         char_in = CH_BACKSLASH;
         cnt_in  = head_cmd.bs_count;
      end else if (remain[1]) begin
         sel     = 4'b0010;
         char_in = head_cmd.ch;
         cnt_in  = 8'd1;
      end else if (remain[2]) begin
         sel     = 4'b0100;
         kind_in = KIND_ARG_END;
      end else begin
         sel     = 4'b1000;
         kind_in = KIND_LINE_END;
      end
   end

   always_comb begin
      done_in  = done_ff;
      valid_in = valid_ff;
      if (load) begin
         valid_in = 1'b1;
         done_in  = last ? 4'd0 : (done_ff | sel);
      end else if (rsp_tready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         done_ff  <= 4'd0;
         valid_ff <= 1'b0;
      end else begin
         done_ff  <= done_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         kind_ff  <= kind_in;
         char_ff  <= char_in;
         cnt_ff   <= cnt_in;
         tlast_ff <= last;
      end
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = {cnt_ff, char_ff};
   assign rsp_tuser  = kind_ff;
   assign rsp_tlast  = tlast_ff;

endmodule

FILE: src/command_line_argument_splitter.sv
// Top level of the command line argument splitter.
//
// req channel: one UTF-16 code unit per transfer in req_tdata; zero ends the line.
// rsp channel: one result per transfer. rsp_tuser holds the kind (character run,
// argument end, line end), rsp_tdata the character and its repeat count, and
// rsp_tlast marks the final result caused by one input character.
// A character enters the command queue at its transfer edge, the sequencer then
// loads the first result into its output register, and that result transfers from
// there. Throughput: one character per cycle while the command queue is not full;
// a character that causes two or three results occupies the result sequencer while
// it sends them, and the four-entry command queue absorbs that. Backslashes, and
// blanks outside quotes in an empty argument, cause no result and do not occupy
// the sequencer.
// req_tready drops only when the command queue is full.
// Reset clears the quote state, the pending backslash count, the queue and the
// output register; the block takes characters in the first cycle after reset.
// When rsp_tready is low the current result holds and the queue fills up
// behind it before input stalls.
module command_line_argument_splitter (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,   // [15:0] char_code
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,   // [15:0] out_char, [23:16] repeat_count
   output logic [1:0]  rsp_tuser,   // [1:0] kind
   output logic        rsp_tlast
);
   import clas_pkg::*;

   logic    accept, push, full, pop, head_valid;
   cmd_type cmd, head_cmd;

   assign req_tready = !full;
   assign accept     = req_tvalid && req_tready;

   clas_front u_front (
      .clock     (clock),
      .reset     (reset),
      .accept    (accept),
      .char_code (req_tdata),
      .push      (push),
      .cmd       (cmd)
   );

   clas_cmd_fifo u_fifo (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_cmd   (cmd),
      .full       (full),
      .pop        (pop),
      .head_valid (head_valid),
      .head_cmd   (head_cmd)
   );

   clas_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (head_valid),
      .head_cmd   (head_cmd),
      .pop        (pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   a_line_end_last: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser == KIND_LINE_END |-> rsp_tlast)
      else $error("line end not marked last");

   a_run_nonzero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser == KIND_RUN |-> rsp_tdata[23:16] != 8'd0)
      else $error("character run with zero count");

   a_mark_no_data: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tuser == KIND_ARG_END || rsp_tuser == KIND_LINE_END)
      |-> rsp_tdata == 24'd0)
      else $error("argument or line end carries data");

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push |-> !full)
      else $error("command queue overflow");

endmodule
